### hdl/bsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsp_pkg: shared types and constants for the BSP point locator
// Field widths, stream packing offsets, node and queue item layouts, codes.
// ----------------------------------------------------------------------------
package bsp_pkg;

    localparam int MAX_NODES_DEF = 4096;

    localparam int COORD_W  = 32;
    localparam int LINK_W   = 16;
    localparam int NIDX_W   = 12;
    localparam int COUNT_W  = 13;
    localparam int LEAF_W   = 15;
    localparam int LEAF_BIT = 15;
    localparam int HALF_W   = 16;
    localparam int PROD_W   = COORD_W + HALF_W;

    // Input tdata layout, lowest bit first
    localparam int NIDX_LSB   = 0;
    localparam int LX_LSB     = NIDX_LSB + NIDX_W;
    localparam int LY_LSB     = LX_LSB + COORD_W;
    localparam int LDX_LSB    = LY_LSB + COORD_W;
    localparam int LDY_LSB    = LDX_LSB + COORD_W;
    localparam int CFRONT_LSB = LDY_LSB + COORD_W;
    localparam int CBACK_LSB  = CFRONT_LSB + LINK_W;
    localparam int QX_LSB     = CBACK_LSB + LINK_W;
    localparam int QY_LSB     = QX_LSB + COORD_W;
    localparam int S_USED_W   = QY_LSB + COORD_W;
    localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((LEAF_W + 7) / 8) * 8;

    // Power of two
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic
    {
        REQ_WRITE = 1'b0,
        REQ_QUERY = 1'b1
    } req_t;

    typedef enum logic [1:0]
    {
        OP_WRITE,
        OP_QUERY,
        OP_EMPTY
    } op_t;

    typedef struct packed
    {
        logic        [LINK_W-1:0]  child_back;
        logic        [LINK_W-1:0]  child_front;
        logic signed [COORD_W-1:0] dy;
        logic signed [COORD_W-1:0] dx;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } node_t;

    typedef struct packed
    {
        op_t                       op;
        logic        [NIDX_W-1:0]  node_index;
        logic        [COUNT_W-1:0] limit;
        node_t                     node;
        logic signed [COORD_W-1:0] qx;
        logic signed [COORD_W-1:0] qy;
    } item_t;

    typedef enum logic [2:0]
    {
        WS_IDLE,
        WS_CHECK,
        WS_DIFF,
        WS_MUL,
        WS_CMP
    } walk_state_t;

endpackage : bsp_pkg
`default_nettype wire

### hdl/bsp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsp_front: item intake and classification
// Holds node_count, unpacks stream items and tags each as a node write,
// a tree walk, or an empty-table query. Writes beyond the table are dropped.
// ----------------------------------------------------------------------------
module bsp_front #(
    parameter int MAX_NODES = bsp_pkg::MAX_NODES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [bsp_pkg::COUNT_W-1:0]     cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [bsp_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                            s_tuser,
    input  wire logic                            q_full,
    output logic                                 push,
    output bsp_pkg::item_t                       push_item
);
    import bsp_pkg::*;

    localparam logic [LINK_W-1:0] MAX_LIM = LINK_W'(MAX_NODES);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] limit;
    logic               in_range;
    logic               accept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            count_reg <= cfg_data;
        end
    end

    // Clamp node_count to the table size
    always_comb
    begin
        if ({{(LINK_W-COUNT_W){1'b0}}, count_reg} > MAX_LIM)
        begin
            limit = MAX_LIM[COUNT_W-1:0];
        end
        else
        begin
            limit = count_reg;
        end
    end

    assign in_range = {{(LINK_W-NIDX_W){1'b0}}, s_tdata[NIDX_LSB +: NIDX_W]} < MAX_LIM;

    always_comb
    begin
        push_item.node_index       = s_tdata[NIDX_LSB +: NIDX_W];
        push_item.limit            = limit;
        push_item.node.x           = s_tdata[LX_LSB +: COORD_W];
        push_item.node.y           = s_tdata[LY_LSB +: COORD_W];
        push_item.node.dx          = s_tdata[LDX_LSB +: COORD_W];
        push_item.node.dy          = s_tdata[LDY_LSB +: COORD_W];
        push_item.node.child_front = s_tdata[CFRONT_LSB +: LINK_W];
        push_item.node.child_back  = s_tdata[CBACK_LSB +: LINK_W];
        push_item.qx               = s_tdata[QX_LSB +: COORD_W];
        push_item.qy               = s_tdata[QY_LSB +: COORD_W];
        if (req_t'(s_tuser) == REQ_WRITE)
        begin
            push_item.op = OP_WRITE;
        end
        else if (limit == '0)
        begin
            push_item.op = OP_EMPTY;
        end
        else
        begin
            push_item.op = OP_QUERY;
        end
    end

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    // drop writes that fall outside the table
    assign push     = accept && !((req_t'(s_tuser) == REQ_WRITE) && !in_range);

endmodule : bsp_front
`default_nettype wire

### hdl/bsp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsp_fifo: item queue between intake and walker
// Short first-in first-out buffer of classified items.
// ----------------------------------------------------------------------------
module bsp_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire bsp_pkg::item_t push_item,
    output logic                full,
    input  wire logic           pop,
    output bsp_pkg::item_t      pop_item,
    output logic                not_empty
);
    import bsp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = count_reg == (PTR_W+1)'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule : bsp_fifo
`default_nettype wire

### hdl/bsp_walk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsp_walk: node table and tree walker
// Stores node writes, walks queries from the root one node per table read,
// and holds the finished result in an output register.
// ----------------------------------------------------------------------------
module bsp_walk #(
    parameter int MAX_NODES = bsp_pkg::MAX_NODES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire bsp_pkg::item_t                q_item,
    output logic                               pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [bsp_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tuser
);
    import bsp_pkg::*;

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam logic [LINK_W-1:0] MAX_LIM = LINK_W'(MAX_NODES);

    node_t mem [MAX_NODES];

    walk_state_t state_reg;
    walk_state_t state_next;

    logic [LINK_W-1:0]  link_reg;
    logic [COUNT_W-1:0] step_reg;
    logic [COUNT_W-1:0] limit_reg;
    logic               out_valid_reg;
    logic [LEAF_W-1:0]  out_leaf_reg;
    logic               out_abort_reg;

    node_t                     node_reg;
    logic signed [COORD_W-1:0] qx_reg;
    logic signed [COORD_W-1:0] qy_reg;
    logic signed [COORD_W-1:0] ddx_reg;
    logic signed [COORD_W-1:0] ddy_reg;
    logic signed [HALF_W-1:0]  dyh_reg;
    logic signed [HALF_W-1:0]  dxh_reg;
    logic signed [PROD_W-1:0]  left_p_reg;
    logic signed [PROD_W-1:0]  right_p_reg;

    logic                      slot_free;
    logic                      link_leaf;
    logic                      link_bad;
    logic signed [COORD_W-1:0] ddx;
    logic signed [COORD_W-1:0] ddy;
    logic                      dx_zero;
    logic                      dy_zero;
    logic                      quick;
    logic                      quick_side;
    logic signed [COORD_W-1:0] left_v;
    logic signed [COORD_W-1:0] right_v;
    logic                      prod_side;

    // control strobes
    logic              mem_we;
    logic              mem_re;
    logic              start_walk;
    logic              take_child;
    logic              child_side;
    logic              finish;
    logic [LEAF_W-1:0] fin_leaf;
    logic              fin_abort;

    assign slot_free = !out_valid_reg || m_tready;
    assign link_leaf = link_reg[LEAF_BIT];
    assign link_bad  = (step_reg >= limit_reg) || (link_reg >= MAX_LIM);

    // Side test, first half: special lines and the sign shortcut
    assign ddx     = qx_reg - node_reg.x;
    assign ddy     = qy_reg - node_reg.y;
    assign dx_zero = node_reg.dx == '0;
    assign dy_zero = node_reg.dy == '0;
    assign quick   = dx_zero || dy_zero ||
                     (node_reg.dy[COORD_W-1] ^ node_reg.dx[COORD_W-1] ^
                      ddx[COORD_W-1] ^ ddy[COORD_W-1]);

    always_comb
    begin
        priority if (dx_zero)
        begin
            quick_side = (qx_reg <= node_reg.x) ? (node_reg.dy > 0) : (node_reg.dy < 0);
        end
        else if (dy_zero)
        begin
            quick_side = (qy_reg <= node_reg.y) ? (node_reg.dx < 0) : (node_reg.dx > 0);
        end
        else
        begin
            quick_side = node_reg.dy[COORD_W-1] ^ ddx[COORD_W-1];
        end
    end

    // Side test, second half: compare the scaled cross products
    assign left_v    = left_p_reg[PROD_W-1 -: COORD_W];
    assign right_v   = right_p_reg[PROD_W-1 -: COORD_W];
    assign prod_side = !(right_v < left_v);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            WS_IDLE:
            begin
                if (q_valid && (q_item.op == OP_QUERY))
                begin
                    state_next = WS_CHECK;
                end
            end
            WS_CHECK:
            begin
                if (link_leaf || link_bad)
                begin
                    if (slot_free)
                    begin
                        state_next = WS_IDLE;
                    end
                end
                else
                begin
                    state_next = WS_DIFF;
                end
            end
            WS_DIFF:
            begin
                state_next = quick ? WS_CHECK : WS_MUL;
            end
            WS_MUL:
            begin
                state_next = WS_CMP;
            end
            WS_CMP:
            begin
                state_next = WS_CHECK;
            end
            default:
            begin
                state_next = WS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop        = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        start_walk = 1'b0;
        take_child = 1'b0;
        child_side = 1'b0;
        finish     = 1'b0;
        fin_leaf   = '0;
        fin_abort  = 1'b0;
        unique case (state_reg)
            WS_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_item.op)
                        OP_WRITE:
                        begin
                            pop    = 1'b1;
                            mem_we = 1'b1;
                        end
                        OP_QUERY:
                        begin
                            pop        = 1'b1;
                            start_walk = 1'b1;
                        end
                        OP_EMPTY:
                        begin
                            pop    = slot_free;
                            finish = slot_free;
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            WS_CHECK:
            begin
                if (link_leaf)
                begin
                    finish   = slot_free;
                    fin_leaf = link_reg[LEAF_W-1:0];
                end
                else if (link_bad)
                begin
                    finish    = slot_free;
                    fin_abort = 1'b1;
                end
                else
                begin
                    mem_re = 1'b1;
                end
            end
            WS_DIFF:
            begin
                take_child = quick;
                child_side = quick_side;
            end
            WS_MUL:
            begin
            end
            WS_CMP:
            begin
                take_child = 1'b1;
                child_side = prod_side;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= WS_IDLE;
            link_reg      <= '0;
            step_reg      <= '0;
            limit_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (start_walk)
            begin
                limit_reg <= q_item.limit;
                link_reg  <= {{(LINK_W-COUNT_W){1'b0}}, q_item.limit} - 1'b1;
                step_reg  <= '0;
            end
            else if (take_child)
            begin
                link_reg <= child_side ? node_reg.child_back : node_reg.child_front;
                step_reg <= step_reg + 1'b1;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[AW'({{(LINK_W-NIDX_W){1'b0}}, q_item.node_index})] <= q_item.node;
        end
        if (mem_re)
        begin
            node_reg <= mem[link_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_walk)
        begin
            qx_reg <= q_item.qx;
            qy_reg <= q_item.qy;
        end
        if (state_reg == WS_DIFF)
        begin
            ddx_reg <= ddx;
            ddy_reg <= ddy;
            dyh_reg <= node_reg.dy[COORD_W-1 -: HALF_W];
            dxh_reg <= node_reg.dx[COORD_W-1 -: HALF_W];
        end
        if (state_reg == WS_MUL)
        begin
            left_p_reg  <= dyh_reg * ddx_reg;
            right_p_reg <= ddy_reg * dxh_reg;
        end
        if (finish)
        begin
            out_leaf_reg  <= fin_leaf;
            out_abort_reg <= fin_abort;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-LEAF_W){1'b0}}, out_leaf_reg};
    assign m_tuser  = out_abort_reg;

`ifndef SYNTHESIS
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == WS_CHECK) |-> (step_reg <= limit_reg))
        else $error("walk step count passed the node limit");

    a_read_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |-> (!link_reg[LEAF_BIT] && (link_reg < MAX_LIM)))
        else $error("table read outside the node range");

    a_abort_leaf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_abort_reg) |-> (out_leaf_reg == '0))
        else $error("aborted walk reports a nonzero leaf");

    a_diff_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == WS_DIFF) |-> $past(mem_re))
        else $error("side test without a fresh node read");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == WS_IDLE))
        else $error("queue popped while a walk is running");
`endif

endmodule : bsp_walk
`default_nettype wire

### hdl/bsp_point_locate_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsp_point_locate_top: BSP tree point location
// Loads partition nodes and returns the leaf region that holds a query point.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  cfg      cfg_valid/cfg_ready  cfg_data: node_count
//  s        s_tvalid/s_tready    s_tuser: req_type; s_tdata: node and query fields
//  m        m_tvalid/m_tready    m_tuser: walk_aborted; m_tdata: leaf_index
//
//  Query: started in WS_IDLE; per node, WS_CHECK reads the single-port
//  table, WS_DIFF tests vertical/horizontal lines and the sign shortcut, and
//  the two-stage multiply/compare in WS_MUL and WS_CMP does the product
//  compare; WS_CHECK ends the walk. A two-item queue parts intake from the
//  walker and a result register parts the walker from m. The node table
//  has no reset and no clearing pass; other control state clears on rst_n.
// ----------------------------------------------------------------------------
module bsp_point_locate_top #(
    parameter int MAX_NODES = bsp_pkg::MAX_NODES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bsp_pkg::COUNT_W-1:0]   cfg_data,   // node_count
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // node_index, line_x, line_y, line_dx, line_dy, child_front, child_back,
    // query_x, query_y
    input  wire logic [bsp_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          s_tuser,    // req_type
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [bsp_pkg::M_TDATA_W-1:0]      m_tdata,    // leaf_index
    output logic                               m_tuser     // walk_aborted
);
    import bsp_pkg::*;

    logic  q_full;
    logic  push;
    item_t push_item;
    logic  pop;
    item_t pop_item;
    logic  q_valid;

    bsp_front #(
        .MAX_NODES (MAX_NODES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    bsp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .not_empty (q_valid)
    );

    bsp_walk #(
        .MAX_NODES (MAX_NODES)
    ) u_walk (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (pop_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule : bsp_point_locate_top
`default_nettype wire

### tb/bsp_point_locate_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_point_locate_top_tb: self-checking bench for the BSP point locator
// A short directed table walks empty tables, axis-aligned lines, looping and
// out-of-range links and oversized node counts. Random phases then rebuild
// small trees and query them. Results are checked against a local walk model
// or typed rows' values, while both stream sides idle at random in two phases.
// ----------------------------------------------------------------------------
module bsp_point_locate_top_tb;

    import bsp_pkg::*;

    localparam int ITEMS_TOTAL = 1350;
    localparam logic [LINK_W-1:0] LEAF_LINK = 16'h8000;

    typedef struct
    {
        req_t                      kind;
        logic        [NIDX_W-1:0]  node_index;
        node_t                     node;
        logic signed [COORD_W-1:0] qx;
        logic signed [COORD_W-1:0] qy;
    } bsp_req_t;

    typedef struct
    {
        logic [LEAF_W-1:0] leaf;
        logic              aborted;
    } leaf_result_t;

    typedef enum
    {
        ROW_CFG,
        ROW_ITEM
    } row_kind_t;

    typedef struct
    {
        row_kind_t          kind;
        logic [COUNT_W-1:0] count;
        bsp_req_t           req;
        bit                 typed;
        leaf_result_t       result;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [COUNT_W-1:0]    cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;

    node_t        node_mirror [MAX_NODES_DEF];
    bit           node_written [MAX_NODES_DEF];
    int           written_list [$];
    int unsigned  node_count_shadow = 0;
    leaf_result_t pending_leaves [$];
    stim_row_t    dir_rows [$];

    int src_idle_pct = 24;
    int dst_idle_pct = 47;
    int items_sent = 0;
    int mismatch_count = 0;

    bsp_point_locate_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #10 clk = ~clk;

    // 0 picks the front child, 1 the back child
    function automatic logic side_of_line(int qx, int qy, node_t n);
        int nx;
        int ny;
        int ndx;
        int ndy;
        int ddx;
        int ddy;
        int left;
        int right;
        logic [31:0] signs;
        nx = n.x;
        ny = n.y;
        ndx = n.dx;
        ndy = n.dy;
        if (ndx == 0)
            return (qx <= nx) ? (ndy > 0) : (ndy < 0);
        if (ndy == 0)
            return (qy <= ny) ? (ndx < 0) : (ndx > 0);
        ddx = qx - nx;
        ddy = qy - ny;
        signs = ndy ^ ndx ^ ddx ^ ddy;
        if (signs[31])
            return ndy[31] ^ ddx[31];
        left = int'((longint'(ndy >>> 16) * longint'(ddx)) >>> 16);
        right = int'((longint'(ddy) * longint'(ndx >>> 16)) >>> 16);
        return !(right < left);
    endfunction

    function automatic leaf_result_t locate_leaf(int qx, int qy);
        int unsigned  lim;
        int unsigned  steps;
        logic [15:0]  link;
        leaf_result_t res;
        res.leaf = '0;
        res.aborted = 1'b0;
        lim = (node_count_shadow > MAX_NODES_DEF) ? MAX_NODES_DEF : node_count_shadow;
        if (lim == 0)
            return res;
        link = 16'(lim - 1);
        steps = 0;
        while (1'b1)
        begin
            if (link[LEAF_BIT])
            begin
                res.leaf = link[LEAF_W-1:0];
                return res;
            end
            if (steps >= lim || link >= MAX_NODES_DEF)
            begin
                res.aborted = 1'b1;
                return res;
            end
            if (side_of_line(qx, qy, node_mirror[link[NIDX_W-1:0]]))
                link = node_mirror[link[NIDX_W-1:0]].child_back;
            else
                link = node_mirror[link[NIDX_W-1:0]].child_front;
            steps++;
        end
        return res;
    endfunction

    function automatic logic [31:0] rand_coord(int unsigned full_pct);
        if ($urandom_range(0, 99) < full_pct)
            return $urandom;
        return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
    endfunction

    function automatic logic [31:0] rand_dir();
        logic [31:0] corners [6];
        corners = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                    32'h0000_0001, 32'h0001_0000, 32'hFFFF_0000};
        if ($urandom_range(0, 99) < 15)
            return corners[$urandom_range(0, 5)];
        return rand_coord(40);
    endfunction

    // Links only reach nodes that already hold data, so no walk reads an empty entry
    function automatic logic [LINK_W-1:0] rand_link();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 25 || written_list.size() == 0)
            return {1'b1, 15'($urandom)};
        if (r < 28)
            return 16'($urandom_range(MAX_NODES_DEF, 32767));
        return 16'(written_list[$urandom_range(0, written_list.size() - 1)]);
    endfunction

    function automatic node_t random_node();
        node_t       n;
        int unsigned r;
        r = $urandom_range(0, 99);
        n.x = rand_coord(30);
        n.y = rand_coord(30);
        n.dx = (r < 10) ? '0 : rand_dir();
        n.dy = (r >= 10 && r < 20) ? '0 : rand_dir();
        n.child_front = rand_link();
        n.child_back = rand_link();
        return n;
    endfunction

    function automatic stim_row_t blank_row(row_kind_t kind);
        stim_row_t row;
        row.kind = kind;
        row.count = '0;
        row.req.kind = REQ_WRITE;
        row.req.node_index = '0;
        row.req.node = '0;
        row.req.qx = '0;
        row.req.qy = '0;
        row.typed = 1'b0;
        row.result.leaf = '0;
        row.result.aborted = 1'b0;
        return row;
    endfunction

    function automatic void row_cfg(int unsigned count);
        stim_row_t row;
        row = blank_row(ROW_CFG);
        row.count = COUNT_W'(count);
        dir_rows.push_back(row);
    endfunction

    function automatic void row_write(int unsigned idx, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] dx, logic [31:0] dy,
                                      logic [LINK_W-1:0] cf, logic [LINK_W-1:0] cb);
        stim_row_t row;
        row = blank_row(ROW_ITEM);
        row.req.kind = REQ_WRITE;
        row.req.node_index = NIDX_W'(idx);
        row.req.node.x = x;
        row.req.node.y = y;
        row.req.node.dx = dx;
        row.req.node.dy = dy;
        row.req.node.child_front = cf;
        row.req.node.child_back = cb;
        dir_rows.push_back(row);
    endfunction

    function automatic void row_query(logic [31:0] qx, logic [31:0] qy, bit typed,
                                      logic [LEAF_W-1:0] leaf, logic aborted);
        stim_row_t row;
        row = blank_row(ROW_ITEM);
        row.req.kind = REQ_QUERY;
        row.req.qx = qx;
        row.req.qy = qy;
        row.typed = typed;
        row.result.leaf = leaf;
        row.result.aborted = aborted;
        dir_rows.push_back(row);
    endfunction

    // Enter and leave at a falling edge
    task automatic send_req(input bsp_req_t r, input bit typed, input leaf_result_t given);
        logic [S_TDATA_W-1:0] word;
        case (items_sent * 3 / ITEMS_TOTAL)
            0:
            begin
                src_idle_pct = 24;
                dst_idle_pct = 47;
            end
            1:
            begin
                src_idle_pct = 47;
                dst_idle_pct = 24;
            end
            default:
            begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
        endcase
        word = '0;
        word[NIDX_LSB +: NIDX_W] = r.node_index;
        word[LX_LSB +: COORD_W] = r.node.x;
        word[LY_LSB +: COORD_W] = r.node.y;
        word[LDX_LSB +: COORD_W] = r.node.dx;
        word[LDY_LSB +: COORD_W] = r.node.dy;
        word[CFRONT_LSB +: LINK_W] = r.node.child_front;
        word[CBACK_LSB +: LINK_W] = r.node.child_back;
        word[QX_LSB +: COORD_W] = r.qx;
        word[QY_LSB +: COORD_W] = r.qy;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= r.kind;
        s_tdata <= word;
        do
            @(posedge clk);
        while (!s_tready);
        if (r.kind == REQ_WRITE)
        begin
            node_mirror[r.node_index] = r.node;
            if (!node_written[r.node_index])
            begin
                node_written[r.node_index] = 1'b1;
                written_list.push_back(int'(r.node_index));
            end
        end
        else if (typed)
            pending_leaves.push_back(given);
        else
            pending_leaves.push_back(locate_leaf(r.qx, r.qy));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_node_write(input int unsigned idx);
        bsp_req_t     r;
        leaf_result_t none;
        none = '{default: '0};
        r.kind = REQ_WRITE;
        r.node_index = NIDX_W'(idx);
        r.node = random_node();
        r.qx = $urandom;
        r.qy = $urandom;
        send_req(r, 1'b0, none);
    endtask

    // Change node_count only with the walker drained
    task automatic load_node_count(input int unsigned count);
        s_tvalid <= 1'b0;
        while (pending_leaves.size() != 0)
            @(negedge clk);
        // a trailing node write leaves no result behind, give it time to land
        repeat (8) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= COUNT_W'(count);
        do
            @(posedge clk);
        while (!cfg_ready);
        node_count_shadow = count;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end

    always @(posedge clk)
    begin
        leaf_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_leaves.size() == 0)
            begin
                $display("%0t: result with none expected: expected nothing, actual leaf %0d aborted %0b",
                         $time, m_tdata, m_tuser);
                mismatch_count++;
            end
            else
            begin
                want = pending_leaves.pop_front();
                if (m_tdata !== M_TDATA_W'(want.leaf))
                begin
                    $display("%0t: leaf_index mismatch: expected %0d, actual %0d",
                             $time, want.leaf, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser !== want.aborted)
                begin
                    $display("%0t: walk_aborted mismatch: expected %0b, actual %0b",
                             $time, want.aborted, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        bsp_req_t     req;
        leaf_result_t none;
        int unsigned  count;
        int unsigned  lim;
        int unsigned  root;
        int unsigned  n_build;
        int unsigned  n_body;
        int unsigned  idx;
        int           big_phases;
        none = '{default: '0};
        big_phases = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        row_cfg(0);
        row_query(0, 0, 1, 0, 0);
        row_query(32'h8000_0000, 32'h7FFF_FFFF, 1, 0, 0);
        // vertical line through the origin
        row_write(0, 0, 0, 0, 32'h0001_0000, LEAF_LINK | 16'd5, LEAF_LINK | 16'h7FFF);
        row_cfg(1);
        row_query(0, 32'h0005_0000, 1, 15'h7FFF, 0);
        row_query(1, 0, 1, 5, 0);
        // horizontal line, back side falls through to node 0
        row_write(1, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 0, LEAF_LINK, 16'd0);
        row_cfg(2);
        row_query(32'h8000_0000, 32'h0002_0000, 0, 0, 0);
        row_query(0, 32'h7FFF_FFFF, 1, 0, 0);
        // node that loops on itself
        row_write(2, 32'h0004_0000, 32'hFFFC_0000, 32'h0003_0000, 32'h0005_0000, 16'd2, 16'd2);
        row_cfg(3);
        row_query(0, 0, 1, 0, 1);
        // both links point past the table
        row_write(3, 0, 0, 32'h0001_0000, 32'h0001_0000, 16'h1000, 16'h7FFF);
        row_cfg(4);
        row_query(32'h0003_0000, 32'hFFFF_0000, 1, 0, 1);
        row_write(4095, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  16'd1, 16'd0);
        row_cfg(8191);
        row_query(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0);
        row_cfg(4096);
        row_query(32'h1234_5678, 32'hEDCB_A988, 0, 0, 0);
        row_write(5, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                  LEAF_LINK | 16'd11, LEAF_LINK | 16'd12);
        row_cfg(6);
        row_query(32'h0005_0000, 0, 0, 0, 0);
        row_query(32'h0003_0000, 32'h0004_0000, 0, 0, 0);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                load_node_count(dir_rows[i].count);
            else
                send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].result);
        end

        while (items_sent < ITEMS_TOTAL)
        begin
            idx = $urandom_range(0, 99);
            if (idx < 4)
                count = 0;
            else if (idx < 8 && big_phases < 4)
            begin
                big_phases++;
                case ($urandom_range(0, 3))
                    0: count = 4095;
                    1: count = 4096;
                    2: count = 8191;
                    default: count = $urandom_range(4097, 8190);
                endcase
            end
            else if (idx < 16)
                count = $urandom_range(25, 200);
            else
                count = $urandom_range(1, 24);
            load_node_count(count);
            lim = (count > MAX_NODES_DEF) ? MAX_NODES_DEF : count;
            root = (lim == 0) ? 0 : lim - 1;

            // build the tree bottom up so the root links into filled entries
            if (lim != 0)
            begin
                n_build = (lim <= 24) ? lim : 16;
                for (int k = 0; k < n_build; k++)
                begin
                    if (lim <= 24)
                        idx = k;
                    else
                        idx = (k == n_build - 1) ? root : $urandom_range(0, lim - 1);
                    if (!node_written[idx] || $urandom_range(0, 99) < 30)
                        send_node_write(idx);
                end
            end

            n_body = (lim == 0) ? 6 : (lim > 200) ? 3 : $urandom_range(10, 30);
            for (int k = 0; k < n_body; k++)
            begin
                if (lim != 0 && $urandom_range(0, 99) < 15)
                begin
                    if ($urandom_range(0, 99) < 10)
                        send_node_write($urandom_range(0, MAX_NODES_DEF - 1));
                    else
                        send_node_write($urandom_range(0, lim - 1));
                end
                else
                begin
                    req.kind = REQ_QUERY;
                    req.node_index = NIDX_W'($urandom);
                    req.node = node_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
                    if (lim != 0 && $urandom_range(0, 99) < 20)
                    begin
                        // land on or next to the root line
                        req.qx = node_mirror[root].x + $urandom_range(0, 2) - 32'd1;
                        req.qy = node_mirror[root].y + $urandom_range(0, 2) - 32'd1;
                    end
                    else
                    begin
                        req.qx = rand_coord(35);
                        req.qy = rand_coord(35);
                    end
                    send_req(req, 1'b0, none);
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending_leaves.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("%0t: timeout, %0d results still outstanding", $time, pending_leaves.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
